[rtl/tp_pkg.sv]
// ----------------------------------------------------------------------------
// tp_pkg
// Shared types, constants and rounding helper for the transition
// probability pipeline.
// ----------------------------------------------------------------------------
package tp_pkg;

  localparam int XW = 38;

  localparam logic [62:0] ONE_Q62 = 63'h4000_0000_0000_0000;
  localparam logic [XW-1:0] XCAP = 38'h20_0000_0000;

  typedef logic [30:0] prob_t;

  typedef struct packed {
    prob_t to_a;
    prob_t to_c;
    prob_t to_g;
    prob_t to_t;
  } row_t;

  // Clamps a Q.60 entry to [0, 1.0] and rounds it to nearest Q.30.
  function automatic prob_t to_q30(input logic signed [64:0] v);
    logic [60:0] cl;
    logic [61:0] s;
    if (v < 65'sd0) begin
      cl = '0;
    end else if (v > 65'sh1000_0000_0000_0000) begin
      cl = 61'h1000_0000_0000_0000;
    end else begin
      cl = v[60:0];
    end
    s = {1'b0, cl} + 62'h2000_0000;
    return s[60:30];
  endfunction

endpackage

[rtl/tamura92_transition_probs.sv]
// ----------------------------------------------------------------------------
// tamura92_transition_probs
// Tamura 1992 nucleotide transition probability matrix in fixed point.
//
// A request is taken when start is high and busy is low; it carries the
// start age, end age and rate scale. Each request yields four rows, A, C,
// G and T, on consecutive cycles, each marked by out_valid for one cycle;
// the T row carries out_last_row. The receiver takes every row as shown.
// A new request is not taken while busy is high; busy rises after each
// accept and drops while earlier requests are still in the pipeline.
// Inside, a pipeline with a 40-stage divider that yields 38 quotient bits,
// a 113-stage exponential and a row sequencer holds many requests in flight.
// The GC fraction and kappa registers sit on an APB-style port at byte
// addresses 0 and 4. They are to be written only while no request is in
// flight; the block itself does not enforce this rule on the user.
// Reset sets GC to one half and kappa to one, and empties the pipeline.
// ----------------------------------------------------------------------------
module tamura92_transition_probs import tp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_start_age,
  input  logic [31:0] in_end_age,
  input  logic [31:0] in_rate_scale,
  output logic        out_valid,
  output logic [1:0]  out_row_index,
  output logic [30:0] out_prob_to_a,
  output logic [30:0] out_prob_to_c,
  output logic [30:0] out_prob_to_g,
  output logic [30:0] out_prob_to_t,
  output logic        out_last_row,
  output logic        out_time_clamped
);

  typedef enum logic {REG_GC = 1'b0, REG_KAPPA = 1'b1} reg_idx_t;

  logic [16:0] gc_r;
  logic [23:0] kappa_r;
  logic [16:0] g;
  logic [16:0] gm;
  logic [31:0] gg_r;
  logic [54:0] den_r;
  logic [24:0] kp;
  reg_idx_t    idx;

  logic [1:0]  cnt_r;
  logic        accept;

  logic        v1_r, v2_r;
  logic [31:0] s_r, f_r, rt_r;
  logic [31:0] el;
  logic        cl2_r;
  logic [63:0] t_r;

  logic          x1_vld, x1_tag;
  logic [XW-1:0] x1;
  logic          v3_r, cl3_r;
  logic [XW-1:0] x1d_r, x2_r;
  logic [62:0]   x2p;

  logic  e1_vld, e1_tag;
  prob_t e1, e2;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);
  assign g      = (gc_r > 17'h10000) ? 17'h10000 : gc_r;
  assign gm     = 17'h10000 - g;
  assign kp     = 25'h10000 + 25'(kappa_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gc_r    <= 17'h08000;
      kappa_r <= 24'h010000;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_GC:    gc_r    <= pwdata[16:0];
        REG_KAPPA: kappa_r <= pwdata[23:0];
        default:   gc_r    <= gc_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GC:    prdata = {15'd0, gc_r};
      REG_KAPPA: prdata = {8'd0, kappa_r};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    gg_r  <= g * gm;
    den_r <= 55'h0_8000_0000_0000 + kappa_r * gg_r;
  end

  assign busy   = (cnt_r != 2'd0);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
    end else begin
      cnt_r <= accept ? 2'd3 : (busy ? cnt_r - 2'd1 : cnt_r);
      v1_r  <= accept;
      v2_r  <= v1_r;
      v3_r  <= x1_vld;
    end
  end

  assign el  = (s_r >= f_r) ? s_r - f_r : '0;
  assign x2p = x1 * kp;

  always_ff @(posedge clk) begin
    s_r   <= in_start_age;
    f_r   <= in_end_age;
    rt_r  <= in_rate_scale;
    cl2_r <= (s_r < f_r);
    t_r   <= rt_r * el;
    cl3_r <= x1_tag;
    x1d_r <= x1;
    x2_r  <= (x2p[62:17] > 46'(XCAP)) ? XCAP : x2p[54:17];
  end

  tp_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (v2_r),
    .in_tag  (cl2_r),
    .in_t    (t_r),
    .in_den  (den_r),
    .out_vld (x1_vld),
    .out_tag (x1_tag),
    .out_x   (x1)
  );

  tp_exp u_exp1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (v3_r),
    .in_tag  (cl3_r),
    .in_x    (x1d_r),
    .out_vld (e1_vld),
    .out_tag (e1_tag),
    .out_e   (e1)
  );

  tp_exp u_exp2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (v3_r),
    .in_tag  (1'b0),
    .in_x    (x2_r),
    .out_vld (),
    .out_tag (),
    .out_e   (e2)
  );

  tp_rows u_rows (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_vld           (e1_vld),
    .in_clamp         (e1_tag),
    .in_e1            (e1),
    .in_e2            (e2),
    .in_a             ({gm, 14'd0} >> 1),
    .in_c             ({g, 14'd0} >> 1),
    .out_valid        (out_valid),
    .out_row_index    (out_row_index),
    .out_prob_to_a    (out_prob_to_a),
    .out_prob_to_c    (out_prob_to_c),
    .out_prob_to_g    (out_prob_to_g),
    .out_prob_to_t    (out_prob_to_t),
    .out_last_row     (out_last_row),
    .out_time_clamped (out_time_clamped)
  );

endmodule

[rtl/tp_mulq62.sv]
// ----------------------------------------------------------------------------
// tp_mulq62
// Two-stage Q.62 multiplier: four partial products of the 32-bit low and
// 31-bit high halves, then the sum truncated to Q.62.
// ----------------------------------------------------------------------------
module tp_mulq62 import tp_pkg::*; #(
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [TW-1:0] in_tag,
  input  logic [62:0]   in_a,
  input  logic [62:0]   in_b,
  output logic          out_vld,
  output logic [TW-1:0] out_tag,
  output logic [62:0]   out_p
);

  logic          vld1_r, vld2_r;
  logic [TW-1:0] tag1_r, tag2_r;
  logic [63:0]   ll_r;
  logic [62:0]   lh_r, hl_r;
  logic [61:0]   hh_r;
  logic [62:0]   ll_nxt_dummy;
  logic [126:0]  sum;
  logic [62:0]   p_r;

  assign ll_nxt_dummy = '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    tag1_r <= in_tag;
    ll_r   <= in_a[31:0] * in_b[31:0];
    lh_r   <= in_a[31:0] * in_b[62:32];
    hl_r   <= in_a[62:32] * in_b[31:0];
    hh_r   <= in_a[62:32] * in_b[62:32];
    tag2_r <= tag1_r;
    p_r    <= sum[124:62] | ll_nxt_dummy;
  end

  always_comb begin
    sum = {1'b0, hh_r, 64'd0} + {32'd0, lh_r, 32'd0} + {32'd0, hl_r, 32'd0}
        + {63'd0, ll_r};
  end

  assign out_vld = vld2_r;
  assign out_tag = tag2_r;
  assign out_p   = p_r;

endmodule

[rtl/tp_divn.sv]
// ----------------------------------------------------------------------------
// tp_divn
// One Horner step tail: divides a Q.62 product by a small constant through
// reciprocal multiplies on two halves, then subtracts the quotient from 1.0.
// ----------------------------------------------------------------------------
module tp_divn import tp_pkg::*; #(
  parameter int N  = 1,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [TW-1:0] in_tag,
  input  logic [62:0]   in_p,
  output logic          out_vld,
  output logic [TW-1:0] out_tag,
  output logic [62:0]   out_e
);

  localparam logic [33:0] MH = 34'((65'd1 << 33) / N);
  localparam logic [34:0] ML = 35'((65'd1 << 34) / N);
  localparam logic [37:0] NL = 38'(N);

  logic [3:0]    vld_r;
  logic [TW-1:0] tag_r [0:3];

  logic [32:0] pha_r, qh0_r, qhb_r, qhc_r;
  logic [29:0] pla_r, plb_r;
  logic [4:0]  rhb_r;
  logic [34:0] vc_r;
  logic [30:0] ql0_r;
  logic [62:0] e_r;

  logic [66:0] prodh;
  logic [37:0] diffh;
  logic [34:0] vb;
  logic [69:0] prodl;
  logic [37:0] diffl;
  logic [30:0] ql;
  logic [62:0] q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_comb begin
    prodh = in_p[62:30] * MH;
    diffh = 38'(pha_r) - 38'(qh0_r) * NL;
    vb    = {rhb_r, plb_r};
    prodl = vb * ML;
    diffl = 38'(vc_r) - 38'(ql0_r) * NL;
    ql    = (diffl >= NL) ? ql0_r + 31'd1 : ql0_r;
    q     = {qhc_r, 30'd0} + 63'(ql);
  end

  always_ff @(posedge clk) begin
    tag_r[0] <= in_tag;
    tag_r[1] <= tag_r[0];
    tag_r[2] <= tag_r[1];
    tag_r[3] <= tag_r[2];
    pha_r    <= in_p[62:30];
    pla_r    <= in_p[29:0];
    qh0_r    <= prodh[65:33];
    if (diffh >= NL) begin
      qhb_r <= qh0_r + 33'd1;
      rhb_r <= 5'(diffh - NL);
    end else begin
      qhb_r <= qh0_r;
      rhb_r <= diffh[4:0];
    end
    plb_r <= pla_r;
    vc_r  <= vb;
    ql0_r <= prodl[64:34];
    qhc_r <= qhb_r;
    e_r   <= ONE_Q62 - q;
  end

  assign out_vld = vld_r[3];
  assign out_tag = tag_r[3];
  assign out_e   = e_r;

endmodule

[rtl/tp_exp.sv]
// ----------------------------------------------------------------------------
// tp_exp
// Pipelined exp(-x): sixteen Horner steps on x/256, eight squarings and a
// round to Q.30.
// ----------------------------------------------------------------------------
module tp_exp import tp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic          in_tag,
  input  logic [XW-1:0] in_x,
  output logic          out_vld,
  output logic          out_tag,
  output prob_t         out_e
);

  logic        h_vld [0:16];
  logic [60:0] h_tag [0:16];
  logic [62:0] h_e   [0:16];
  logic        s_vld [0:8];
  logic        s_tag [0:8];
  logic [62:0] s_e   [0:8];
  logic        vld_r, tag_r;
  prob_t       e_r;
  logic [63:0] rnd;

  assign h_vld[0] = in_vld;
  assign h_tag[0] = {in_tag, in_x, 22'd0};
  assign h_e[0]   = ONE_Q62;

  for (genvar s = 0; s < 16; s++) begin : g_horner
    logic        m_vld;
    logic [60:0] m_tag;
    logic [62:0] m_p;

    tp_mulq62 #(.TW(61)) u_mul (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (h_vld[s]),
      .in_tag  (h_tag[s]),
      .in_a    ({3'd0, h_tag[s][59:0]}),
      .in_b    (h_e[s]),
      .out_vld (m_vld),
      .out_tag (m_tag),
      .out_p   (m_p)
    );

    tp_divn #(.N(16 - s), .TW(61)) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (m_vld),
      .in_tag  (m_tag),
      .in_p    (m_p),
      .out_vld (h_vld[s+1]),
      .out_tag (h_tag[s+1]),
      .out_e   (h_e[s+1])
    );
  end

  assign s_vld[0] = h_vld[16];
  assign s_tag[0] = h_tag[16][60];
  assign s_e[0]   = h_e[16];

  for (genvar k = 0; k < 8; k++) begin : g_square
    tp_mulq62 #(.TW(1)) u_sq (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (s_vld[k]),
      .in_tag  (s_tag[k]),
      .in_a    (s_e[k]),
      .in_b    (s_e[k]),
      .out_vld (s_vld[k+1]),
      .out_tag (s_tag[k+1]),
      .out_p   (s_e[k+1])
    );
  end

  assign rnd = {1'b0, s_e[8]} + 64'h8000_0000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= s_vld[8];
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= s_tag[8];
    e_r   <= rnd[62:32];
  end

  assign out_vld = vld_r;
  assign out_tag = tag_r;
  assign out_e   = e_r;

endmodule

[rtl/tp_div.sv]
// ----------------------------------------------------------------------------
// tp_div
// Pipelined restoring divider: floor(T * 2^48 / D) one quotient bit per
// stage, saturated at 32.0 in Q.32.
// ----------------------------------------------------------------------------
module tp_div import tp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic          in_tag,
  input  logic [63:0]   in_t,
  input  logic [54:0]   in_den,
  output logic          out_vld,
  output logic          out_tag,
  output logic [XW-1:0] out_x
);

  logic          vld_r [0:XW];
  logic          tag_r [0:XW];
  logic          sat_r [0:XW];
  logic [54:0]   rem_r [0:XW];
  logic [XW-1:0] quo_r [0:XW];
  logic          sat0;
  logic          ovld_r, otag_r;
  logic [XW-1:0] x_r;

  assign sat0 = {in_t, 10'd0} >= {19'd0, in_den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    tag_r[0] <= in_tag;
    sat_r[0] <= sat0;
    rem_r[0] <= sat0 ? '0 : {in_t[44:0], 10'd0};
    quo_r[0] <= '0;
  end

  for (genvar k = 0; k < XW; k++) begin : g_bit
    logic [55:0] shifted;
    logic        ge;
    logic [55:0] diff;

    assign shifted = {rem_r[k], 1'b0};
    assign ge      = shifted >= {1'b0, in_den};
    assign diff    = shifted - {1'b0, in_den};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      tag_r[k+1] <= tag_r[k];
      sat_r[k+1] <= sat_r[k];
      rem_r[k+1] <= ge ? diff[54:0] : shifted[54:0];
      quo_r[k+1] <= {quo_r[k][XW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= vld_r[XW];
    end
  end

  always_ff @(posedge clk) begin
    otag_r <= tag_r[XW];
    x_r    <= (sat_r[XW] || quo_r[XW] > XCAP) ? XCAP : quo_r[XW];
  end

  assign out_vld = ovld_r;
  assign out_tag = otag_r;
  assign out_x   = x_r;

endmodule

[rtl/tp_rows.sv]
// ----------------------------------------------------------------------------
// tp_rows
// Forms the matrix entries from the two exponentials and sends the four
// rows out on consecutive cycles.
// ----------------------------------------------------------------------------
module tp_rows import tp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic        in_clamp,
  input  prob_t       in_e1,
  input  prob_t       in_e2,
  input  logic [30:0] in_a,
  input  logic [30:0] in_c,
  output logic        out_valid,
  output logic [1:0]  out_row_index,
  output prob_t       out_prob_to_a,
  output prob_t       out_prob_to_c,
  output prob_t       out_prob_to_g,
  output prob_t       out_prob_to_t,
  output logic        out_last_row,
  output logic        out_time_clamped
);

  logic        pv_r, pclamp_r;
  logic [62:0] ap_r, cp_r, a2e_r, c2e_r;
  logic [61:0] am_r, cm_r;
  logic [31:0] p1;
  logic [30:0] m1;
  logic [62:0] ap_nxt, cp_nxt;
  logic [61:0] am_nxt, cm_nxt, ae_nxt, ce_nxt;

  logic        rv_r, rclamp_r;
  row_t        rows_r [0:3];
  logic signed [64:0] sap, scp, sam, scm, sa2e, sc2e;
  prob_t       q_apc, q_cmc, q_cpa, q_apa, q_cm, q_am;

  logic        act_r;
  logic [1:0]  cnt_r;
  logic        ov_r, olast_r, oclamp_r;
  logic [1:0]  oidx_r;
  row_t        orow_r;

  always_comb begin
    p1     = {1'b0, in_e1} + 32'h4000_0000;
    m1     = 31'h4000_0000 - in_e1;
    ap_nxt = in_a * p1;
    cp_nxt = in_c * p1;
    am_nxt = in_a * m1;
    cm_nxt = in_c * m1;
    ae_nxt = in_a * in_e2;
    ce_nxt = in_c * in_e2;
  end

  always_comb begin
    sap   = $signed({2'd0, ap_r});
    scp   = $signed({2'd0, cp_r});
    sam   = $signed({3'd0, am_r});
    scm   = $signed({3'd0, cm_r});
    sa2e  = $signed({2'd0, a2e_r});
    sc2e  = $signed({2'd0, c2e_r});
    q_apc = to_q30(sap + sc2e);
    q_cmc = to_q30(scp - sc2e);
    q_cpa = to_q30(scp + sa2e);
    q_apa = to_q30(sap - sa2e);
    q_cm  = to_q30(scm);
    q_am  = to_q30(sam);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r    <= 1'b0;
      rv_r    <= 1'b0;
      act_r   <= 1'b0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      pv_r <= in_vld;
      rv_r <= pv_r;
      if (rv_r) begin
        ov_r  <= 1'b1;
        act_r <= 1'b1;
        cnt_r <= 2'd1;
      end else if (act_r) begin
        ov_r  <= 1'b1;
        act_r <= (cnt_r != 2'd3);
        cnt_r <= cnt_r + 2'd1;
      end else begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pclamp_r <= in_clamp;
    ap_r     <= ap_nxt;
    cp_r     <= cp_nxt;
    am_r     <= am_nxt;
    cm_r     <= cm_nxt;
    a2e_r    <= {ae_nxt, 1'b0};
    c2e_r    <= {ce_nxt, 1'b0};
    if (pv_r) begin
      rclamp_r <= pclamp_r;
      rows_r[0] <= '{to_a: q_apc, to_c: q_cm,  to_g: q_cmc, to_t: q_am};
      rows_r[1] <= '{to_a: q_am,  to_c: q_cpa, to_g: q_cm,  to_t: q_apa};
      rows_r[2] <= '{to_a: q_apa, to_c: q_cm,  to_g: q_cpa, to_t: q_am};
      rows_r[3] <= '{to_a: q_am,  to_c: q_cmc, to_g: q_cm,  to_t: q_apc};
    end
    if (rv_r) begin
      orow_r   <= rows_r[0];
      oidx_r   <= 2'd0;
      olast_r  <= 1'b0;
      oclamp_r <= rclamp_r;
    end else begin
      orow_r  <= rows_r[cnt_r];
      oidx_r  <= cnt_r;
      olast_r <= (cnt_r == 2'd3);
    end
  end

  assign out_valid        = ov_r;
  assign out_row_index    = oidx_r;
  assign out_prob_to_a    = orow_r.to_a;
  assign out_prob_to_c    = orow_r.to_c;
  assign out_prob_to_g    = orow_r.to_g;
  assign out_prob_to_t    = orow_r.to_t;
  assign out_last_row     = olast_r;
  assign out_time_clamped = oclamp_r;

endmodule

[rtl/tp_chk.sv]
// ----------------------------------------------------------------------------
// tp_chk
// Port-level checks for the transition probability block.
// ----------------------------------------------------------------------------
module tp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_row_index,
  input logic [30:0] out_prob_to_a,
  input logic        out_last_row
);

  a_busy_window: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy ##1 busy ##1 busy ##1 !busy)
    else $error("busy window after a request is wrong");

  a_last_is_t: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_row) |-> (out_row_index == 2'd3))
    else $error("last row is not the T row");

  a_rows_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_row) |=> (out_valid && out_row_index != 2'd0))
    else $error("rows of one matrix are not consecutive");

  a_prob_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_prob_to_a <= 31'h4000_0000))
    else $error("probability above one");

endmodule

bind tamura92_transition_probs tp_chk u_tp_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_row_index (out_row_index),
  .out_prob_to_a (out_prob_to_a),
  .out_last_row  (out_last_row)
);
